@@ hw/rtl/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse register store package
// Shared constants, codes and the search item carried along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 31;
	localparam int DATA_W       = 32;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NEG  = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              op;
		logic              neg;
		logic              alloc_req;
		logic              found;
		logic              alloc_done;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] val;
		logic [DATA_W-1:0] rdata;
	} srs_tok_t;

endpackage

`default_nettype wire

@@ hw/rtl/sparse_register_store.sv @@
// ----------------------------------------------------------------------------
// Sparse register store
// Position-keyed register store built as a row of entry cells.
// ----------------------------------------------------------------------------
// An accepted item walks the row of CAPACITY cells, one cell per cycle; each
// cell compares its key, updates or returns its data, and the first free cell
// takes a new entry. The item leaving the row is registered in a pending
// register and then in the output register once that is free; the result is
// raised on the output and in_ready returns in that same cycle, so the store
// takes no new item until the last result has reached the output. A finished
// result may wait on the output while the next item is already walking; a
// result still held there when the next one leaves the row holds in_ready low.
`default_nettype none

module sparse_register_store
	import srs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic signed [31:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [31:0] position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_data,
	output logic [1:0]         status,
	output logic               was_mapped
);

	localparam int UW = $clog2(CAPACITY + 1);

	srs_tok_t          chain [CAPACITY+1];
	srs_tok_t          exit_tok;
	logic [UW-1:0]     used_q;
	logic [DATA_W-1:0] default_q;
	logic              busy_q;
	logic              pend_valid_q;
	logic [DATA_W-1:0] pend_rdata_q;
	status_t           pend_status_q;
	logic              pend_mapped_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_rdata_q;
	status_t           out_status_q;
	logic              out_mapped_q;
	logic              accept;
	logic              move_out;
	logic [CAPACITY-1:0] live;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign move_out = pend_valid_q && (!out_valid_q || out_ready);

	always_comb begin
		chain[0]            = '0;
		chain[0].valid      = accept;
		chain[0].op         = operation;
		chain[0].neg        = position[31];
		chain[0].key        = position[30:0];
		chain[0].val        = $unsigned(value);
		chain[0].alloc_req  = (operation == OP_WRITE) && !position[31]
		                      && ($unsigned(value) != default_q);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		srs_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.used    (used_q),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
		assign live[i] = chain[i+1].valid;
	end

	assign exit_tok = chain[CAPACITY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q     <= '0;
			used_q        <= UW'(1);
			busy_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			pend_rdata_q  <= '0;
			pend_status_q <= STATUS_OK;
			pend_mapped_q <= 1'b0;
			out_rdata_q   <= '0;
			out_status_q  <= STATUS_OK;
			out_mapped_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				default_q <= $unsigned(cfg_wdata);
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move_out) begin
				busy_q <= 1'b0;
			end
			if (exit_tok.valid) begin
				pend_valid_q  <= 1'b1;
				pend_mapped_q <= exit_tok.found;
				if (exit_tok.neg) begin
					pend_status_q <= STATUS_NEG;
					pend_rdata_q  <= '0;
				end else begin
					if (exit_tok.alloc_req && !exit_tok.found && !exit_tok.alloc_done) begin
						pend_status_q <= STATUS_FULL;
					end else begin
						pend_status_q <= STATUS_OK;
					end
					if (exit_tok.op == OP_WRITE) begin
						pend_rdata_q <= '0;
					end else if (exit_tok.found) begin
						pend_rdata_q <= exit_tok.rdata;
					end else begin
						pend_rdata_q <= default_q;
					end
				end
				if (exit_tok.alloc_done) begin
					used_q <= used_q + UW'(1);
				end
			end else if (move_out) begin
				pend_valid_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q  <= 1'b1;
				out_rdata_q  <= pend_rdata_q;
				out_status_q <= pend_status_q;
				out_mapped_q <= pend_mapped_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = $signed(out_rdata_q);
	assign status     = out_status_q;
	assign was_mapped = out_mapped_q;

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live))
		else $error("more than one item in the cell row");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q >= UW'(1)) && (used_q <= UW'(CAPACITY)))
		else $error("entry count out of range");
	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(live != '0 || pend_valid_q) |-> busy_q)
		else $error("item in flight while idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && live[0])
		else $error("accepted item did not enter the row");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/srs_cell.sv @@
// ----------------------------------------------------------------------------
// Sparse register store cell
// Holds one entry, matches or allocates as the item passes, hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_cell
	import srs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int INDEX    = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(CAPACITY+1)-1:0] used,
	input  srs_tok_t                      tok_in,
	output srs_tok_t                      tok_out
);

	localparam int UW = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	srs_tok_t          tok_q;
	srs_tok_t          tok_d;
	logic              in_use;
	logic              hit;
	logic              alloc;

	assign in_use = UW'(INDEX) < used;
	assign hit    = tok_in.valid && !tok_in.neg && !tok_in.found && in_use
	                && (key_q == tok_in.key);
	assign alloc  = tok_in.valid && tok_in.alloc_req && !tok_in.found
	                && !tok_in.alloc_done && (UW'(INDEX) == used);

	always_comb begin
		tok_d            = tok_in;
		tok_d.found      = tok_in.found || hit;
		tok_d.alloc_done = tok_in.alloc_done || alloc;
		if (hit && tok_in.op == OP_READ) begin
			tok_d.rdata = data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			data_q <= '0;
			tok_q  <= '0;
		end else begin
			if (alloc) begin
				key_q  <= tok_in.key;
				data_q <= tok_in.val;
			end else if (hit && tok_in.op == OP_WRITE) begin
				data_q <= tok_in.val;
			end
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire
